// File: rtl/core/jseu_pkg.sv
// Shared types, character codes and helpers for the JSON string escaper.
package jseu_pkg;

  // Encoding modes held in the configuration register.
  localparam logic [1:0] MODE_UTF8   = 2'd0;
  localparam logic [1:0] MODE_LATIN1 = 2'd1;
  localparam logic [1:0] MODE_MIXED  = 2'd2;
  // The spare code decodes like Latin-1.
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_ENCODING_MODE = 1'b0;

  // Kinds of multi-byte sequence being decoded.
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  // Lead byte masks and patterns.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // Byte values with special treatment.
  localparam logic [7:0] BYTE_CTRL_MAX = 8'h1F;
  localparam logic [7:0] BYTE_QUOTE    = 8'h22;
  localparam logic [7:0] BYTE_BSLASH   = 8'h5C;

  // Output characters.
  localparam logic [6:0] CH_BSLASH  = 7'h5C;
  localparam logic [6:0] CH_LOWER_U = 7'h75;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_LOWER_A = 7'h61;

  localparam int CODE_W = 21;

  // Work handed from the front end to the output sequencer.
  typedef enum logic [1:0] {
    JOB_CHAR = 2'd0,  // one character as is
    JOB_PAIR = 2'd1,  // backslash then the character
    JOB_ESC  = 2'd2   // backslash, u, four to six hex digits
  } job_kind_t;

  typedef struct packed {
    job_kind_t           kind;
    logic [CODE_W-1:0]   code;
  } job_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {3'b000, nib};
    end else begin
      r = CH_LOWER_A + {3'b000, nib} - 7'd10;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/jseu_if.sv
// Valid/ready channel interfaces for the byte input and the character output.
interface jseu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface jseu_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// File: rtl/core/jseu_front.sv
// Front end: accepts input bytes, tracks UTF-8 decoding and issues escape jobs.
module jseu_front
  import jseu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  jseu_in_if.sink     in_ch,
  input  logic [1:0]  mode,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [1:0]        pend_cnt_r, pend_cnt_nxt;
  logic [1:0]        pend_kind_r, pend_kind_nxt;
  logic [CODE_W-1:0] acc_r, acc_nxt;
  logic [CODE_W-1:0] acc_shift;
  logic              has_job;
  logic              accept;
  logic              utf8, mixed;
  logic [7:0]        b;
  logic              last;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign last        = in_ch.last_byte;
  assign utf8        = (mode == MODE_UTF8);
  assign mixed       = (mode == MODE_MIXED);
  assign acc_shift   = {acc_r[CODE_W-7:0], b[5:0]};

  // Classify the byte against the decoder state.
  always_comb begin
    has_job       = 1'b0;
    q_job.kind    = JOB_CHAR;
    q_job.code    = '0;
    pend_cnt_nxt  = pend_cnt_r;
    pend_kind_nxt = pend_kind_r;
    acc_nxt       = acc_r;

    if (pend_cnt_r != 2'd0) begin
      acc_nxt      = acc_shift;
      pend_cnt_nxt = pend_cnt_r - 2'd1;
      if (pend_cnt_r == 2'd1) begin
        has_job       = 1'b1;
        q_job.kind    = JOB_ESC;
        q_job.code    = acc_shift;
        pend_kind_nxt = SEQ_NONE;
        acc_nxt       = '0;
      end
    end else if (b <= BYTE_CTRL_MAX) begin
      has_job    = 1'b1;
      q_job.kind = JOB_ESC;
      q_job.code = {13'd0, b};
    end else if (b == BYTE_QUOTE || b == BYTE_BSLASH) begin
      has_job    = 1'b1;
      q_job.kind = JOB_PAIR;
      q_job.code = {14'd0, b[6:0]};
    end else if (!b[7]) begin
      has_job    = 1'b1;
      q_job.kind = JOB_CHAR;
      q_job.code = {14'd0, b[6:0]};
    end else if ((utf8 || mixed) && (b & LEAD2_MASK) == LEAD2_PAT) begin
      if (last) begin
        // Missing continuation byte reads as zero.
        has_job    = 1'b1;
        q_job.kind = JOB_ESC;
        q_job.code = {10'd0, b[4:0], 6'd0};
      end else begin
        acc_nxt       = {16'd0, b[4:0]};
        pend_cnt_nxt  = 2'd1;
        pend_kind_nxt = SEQ_TWO;
      end
    end else if (utf8) begin
      if ((b & LEAD3_MASK) == LEAD3_PAT) begin
        acc_nxt       = {17'd0, b[3:0]};
        pend_cnt_nxt  = 2'd2;
        pend_kind_nxt = SEQ_THREE;
      end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
        acc_nxt       = {18'd0, b[2:0]};
        pend_cnt_nxt  = 2'd3;
        pend_kind_nxt = SEQ_FOUR;
      end
      // An invalid lead byte leaves no trace.
    end else begin
      has_job    = 1'b1;
      q_job.kind = JOB_ESC;
      q_job.code = {13'd0, b};
    end

    // The end of the string drops any unfinished sequence.
    if (last) begin
      pend_cnt_nxt  = 2'd0;
      pend_kind_nxt = SEQ_NONE;
      acc_nxt       = '0;
    end
  end

  assign q_push = accept && has_job;

  // Decoder state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r  <= 2'd0;
      pend_kind_r <= SEQ_NONE;
      acc_r       <= '0;
    end else if (accept) begin
      pend_cnt_r  <= pend_cnt_nxt;
      pend_kind_r <= pend_kind_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // A sequence in flight always has a kind, and never more bytes than it needs.
  a_pend_kind: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r != 2'd0 |-> pend_kind_r != SEQ_NONE && pend_cnt_r <= pend_kind_r)
    else $error("pending count without a matching sequence kind");

  // A final byte leaves the decoder idle.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> pend_cnt_r == 2'd0 && acc_r == '0)
    else $error("decoder state survives the end of a string");

endmodule

// File: rtl/core/jseu_fifo.sv
// Short job queue between the front end and the output sequencer.
module jseu_fifo
  import jseu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_FULL)
    else $error("job pushed into a full queue");

endmodule

// File: rtl/core/jseu_back.sv
// Output sequencer: expands queued jobs into characters, one output beat a cycle while the output is taken.
module jseu_back
  import jseu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  job_t        head,
  output logic        pop,
  jseu_out_if.source  out_ch
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       out_last_r;
  logic [2:0] digits;
  logic [2:0] last_step;
  logic [2:0] nib_idx;
  logic [3:0] nib;
  logic [6:0] ch;
  logic       adv;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.run_last = out_last_r;

  // Hex digit count follows the size of the code point.
  always_comb begin
    if (head.code > 21'hFFFFF) begin
      digits = 3'd6;
    end else if (head.code > 21'h0FFFF) begin
      digits = 3'd5;
    end else begin
      digits = 3'd4;
    end
  end

  // Nibble shown at the current step, most significant first.
  assign nib_idx = digits + 3'd1 - step_r;

  always_comb begin
    case (nib_idx)
      3'd0:    nib = head.code[3:0];
      3'd1:    nib = head.code[7:4];
      3'd2:    nib = head.code[11:8];
      3'd3:    nib = head.code[15:12];
      3'd4:    nib = head.code[19:16];
      3'd5:    nib = {3'b000, head.code[20]};
      default: nib = 4'd0;
    endcase
  end

  // Character and run length for the job at the head of the queue.
  always_comb begin
    unique case (head.kind)
      JOB_CHAR: begin
        last_step = 3'd0;
        ch        = head.code[6:0];
      end
      JOB_PAIR: begin
        last_step = 3'd1;
        ch        = (step_r == 3'd0) ? CH_BSLASH : head.code[6:0];
      end
      JOB_ESC: begin
        last_step = digits + 3'd1;
        if (step_r == 3'd0) begin
          ch = CH_BSLASH;
        end else if (step_r == 3'd1) begin
          ch = CH_LOWER_U;
        end else begin
          ch = hex_char(nib);
        end
      end
      default: begin
        last_step = 3'd0;
        ch        = head.code[6:0];
      end
    endcase
  end

  // The output register moves whenever it is empty or being taken.
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head_valid && (step_r == last_step);

  always_comb begin
    step_nxt = step_r;
    if (adv && head_valid) begin
      step_nxt = pop ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (adv) begin
        out_valid_r <= head_valid;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (adv && head_valid) begin
      out_char_r <= ch;
      out_last_r <= (step_r == last_step);
    end
  end

  // A run in progress always belongs to a queued job.
  a_step_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 3'd0 |-> head_valid)
    else $error("sequencer mid-run with an empty queue");

  // A single-character job never advances past its first step.
  a_char_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && head.kind == JOB_CHAR |-> step_r == 3'd0)
    else $error("plain character job ran longer than one beat");

endmodule

// File: rtl/core/json_string_escape_utf8_unit.sv
// Path: an accepted input beat is registered into the job queue, then into the output register.
// Throughput: one byte per cycle while each byte yields at most one character and the output
// is taken; the sequencer emits one character per cycle: 2 characters for a quoted byte, 6 to 8 for an escape.
// Longer runs fill the QUEUE_DEPTH-entry job queue and then hold off input via ready.
// Reset (rst_n low, synchronous) clears decoder state, queue, output valid and sets UTF-8.
module json_string_escape_utf8_unit
  import jseu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  jseu_in_if.sink     in_ch,
  jseu_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] mode_r;
  logic       cfg_wr;
  logic       q_push;
  job_t       q_job;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  job_t       q_head;

  // Configuration register: encoding mode.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UTF8;
    end else if (cfg_wr && paddr[2] == REG_ENCODING_MODE) begin
      mode_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ENCODING_MODE) ? {30'd0, mode_r} : 32'd0;

  jseu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .mode   (mode_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  jseu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  jseu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
